// ===== src/smq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package smq_pkg;

	// defaults for the top-level parameters
	localparam int DEF_STACK_DEPTH = 128;
	localparam int DEF_QUEUE_DEPTH = 128;
	localparam int DEF_NUM_QUEUES  = 26;
	localparam int DEF_DATA_WIDTH  = 8;

	// command codes
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_ENQUEUE = 2'd1;
	localparam logic [1:0] CMD_DEQUEUE = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	// status codes
	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_STACK_FULL  = 3'd1;
	localparam logic [2:0] STAT_STACK_EMPTY = 3'd2;
	localparam logic [2:0] STAT_QUEUE_FULL  = 3'd3;
	localparam logic [2:0] STAT_QUEUE_EMPTY = 3'd4;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] value;
		logic [4:0] queue_id;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_value;
	} rsp_item_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic commit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic rsp_valid;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== src/smq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smq_ctrl import smq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire logic     rsp_stall,
	input  wire dp_stat_t stat,
	output ctl_t          ctl
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		ctl.load   = 1'b0;
		ctl.commit = 1'b0;
		cmd_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.load  = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// commit only once the result register can take the item
				if (!stat.rsp_valid || !rsp_stall) begin
					ctl.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (cmd_stall && !ctl.load))
		else $error("item accepted while previous one still in flight");

	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!stat.rsp_valid || !rsp_stall))
		else $error("commit would overwrite an unread result");

endmodule

`default_nettype wire

// ===== src/smq_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smq_dpath import smq_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
	parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ctl_t      ctl,
	output dp_stat_t       stat,
	input  wire cmd_item_t cmd_item,
	input  wire logic      rsp_stall,
	output logic           rsp_valid,
	output rsp_item_t      rsp_item
);

	localparam int SW     = $clog2(STACK_DEPTH);
	localparam int SCW    = $clog2(STACK_DEPTH + 1);
	localparam int PW     = $clog2(QUEUE_DEPTH);
	localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
	localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int QSLOTS = 1 << PW;

	// storage
	logic [DATA_WIDTH-1:0] stk_mem [STACK_DEPTH];
	logic [DATA_WIDTH-1:0] q_mem   [NUM_QUEUES][QSLOTS];

	logic [SCW-1:0] stk_cnt_q;
	logic [PW-1:0]  q_head_q [NUM_QUEUES];
	logic [PW-1:0]  q_tail_q [NUM_QUEUES];
	logic [QCW-1:0] q_cnt_q  [NUM_QUEUES];

	cmd_item_t             cmd_q;
	logic [DATA_WIDTH-1:0] stk_rd_q;
	logic [DATA_WIDTH-1:0] q_rd_q;
	rsp_item_t             rsp_q;
	logic                  rsp_valid_q;

	// lookup side, from the incoming item
	logic          qv_in;
	logic [QW-1:0] idx_in;
	logic [SW-1:0] stk_raddr;

	assign qv_in     = 32'(cmd_item.queue_id) < NUM_QUEUES;
	assign idx_in    = qv_in ? QW'(cmd_item.queue_id) : '0;
	assign stk_raddr = SW'(stk_cnt_q - 1'b1);

	// check side, from the latched item
	logic          qv;
	logic [QW-1:0] idx;
	logic [PW-1:0] tail_nxt;
	logic [PW-1:0] head_nxt;
	logic          stk_full;
	logic          stk_empty;
	logic          q_full;
	logic          q_empty;
	logic          do_push;
	logic          do_enq;
	logic          do_deq;
	rsp_item_t     rsp_nxt;

	always_comb begin
		qv        = 32'(cmd_q.queue_id) < NUM_QUEUES;
		idx       = qv ? QW'(cmd_q.queue_id) : '0;
		stk_full  = stk_cnt_q == SCW'(STACK_DEPTH);
		stk_empty = stk_cnt_q == '0;
		q_full    = !qv || (q_cnt_q[idx] == QCW'(QUEUE_DEPTH));
		q_empty   = !qv || (q_cnt_q[idx] == '0);
		tail_nxt  = (q_tail_q[idx] == PW'(QUEUE_DEPTH - 1)) ? '0 : q_tail_q[idx] + 1'b1;
		head_nxt  = (q_head_q[idx] == PW'(QUEUE_DEPTH - 1)) ? '0 : q_head_q[idx] + 1'b1;
		do_push   = 1'b0;
		do_enq    = 1'b0;
		do_deq    = 1'b0;
		rsp_nxt.status = STAT_OK;
		unique case (cmd_q.cmd)
			CMD_PUSH: begin
				if (stk_full) begin
					rsp_nxt.status = STAT_STACK_FULL;
				end else begin
					do_push = 1'b1;
				end
			end
			CMD_ENQUEUE: begin
				// stack check wins over queue check
				if (stk_empty) begin
					rsp_nxt.status = STAT_STACK_EMPTY;
				end else if (q_full) begin
					rsp_nxt.status = STAT_QUEUE_FULL;
				end else begin
					do_enq = 1'b1;
				end
			end
			CMD_DEQUEUE: begin
				if (q_empty) begin
					rsp_nxt.status = STAT_QUEUE_EMPTY;
				end else begin
					do_deq = 1'b1;
				end
			end
			CMD_NOP: begin
				rsp_nxt.status = STAT_OK;
			end
		endcase
		rsp_nxt.out_value = do_deq ? 8'(q_rd_q) : 8'd0;
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (ctl.commit && do_push) begin
			stk_mem[SW'(stk_cnt_q)] <= DATA_WIDTH'(cmd_q.value);
		end
		if (ctl.load) begin
			stk_rd_q <= stk_mem[stk_raddr];
		end
	end

	// queue memory
	always_ff @(posedge clk) begin
		if (ctl.commit && do_enq) begin
			q_mem[idx][q_tail_q[idx]] <= stk_rd_q;
		end
		if (ctl.load) begin
			q_rd_q <= q_mem[idx_in][q_head_q[idx_in]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_item;
		end
		if (ctl.commit) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stk_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				q_head_q[i] <= '0;
				q_tail_q[i] <= '0;
				q_cnt_q[i]  <= '0;
			end
		end else begin
			if (ctl.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (ctl.commit && do_push) begin
				stk_cnt_q <= stk_cnt_q + 1'b1;
			end
			if (ctl.commit && do_enq) begin
				stk_cnt_q     <= stk_cnt_q - 1'b1;
				q_tail_q[idx] <= tail_nxt;
				q_cnt_q[idx]  <= q_cnt_q[idx] + 1'b1;
			end
			if (ctl.commit && do_deq) begin
				q_head_q[idx] <= head_nxt;
				q_cnt_q[idx]  <= q_cnt_q[idx] - 1'b1;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp_item       = rsp_q;
	assign stat.rsp_valid = rsp_valid_q;

	a_push_grows_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && do_push) |=> (stk_cnt_q == $past(stk_cnt_q) + 1'b1))
		else $error("ok push did not grow the stack by one");

	a_fail_keeps_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && rsp_nxt.status != STAT_OK) |=> $stable(stk_cnt_q))
		else $error("failed command changed the stack");

	a_value_only_on_dequeue: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != STAT_OK) |-> (rsp_q.out_value == 8'd0))
		else $error("nonzero value on a failed result");

endmodule

`default_nettype wire

// ===== src/stack_to_multi_queue_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One LIFO stack and NUM_QUEUES FIFO queues of DATA_WIDTH-bit entries. A push
// puts value on the stack, an enqueue pops the stack top into queue queue_id,
// a dequeue returns the oldest entry of queue queue_id; every command yields
// one result with a status, and a command that fails changes nothing. For
// each item, the accept cycle looks up the queue pointers and reads the stack
// and queue memories (one read port each), the next cycle checks the counts,
// writes at most one memory entry and loads the result register. The next
// item is accepted only after that commit, so the engine never works on two
// items at once; the commit cycle waits while an earlier result is still held
// in the output register under stall. No clearing pass is needed after reset.
module stack_to_multi_queue_engine_unit import smq_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
	parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_item_t cmd_item,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_item_t      rsp_item
);

	ctl_t     ctl;
	dp_stat_t stat;

	smq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	smq_dpath #(
		.STACK_DEPTH (STACK_DEPTH),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_QUEUES  (NUM_QUEUES),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.cmd_item  (cmd_item),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item)
	);

endmodule

`default_nettype wire

// ===== tb/sv/stack_to_multi_queue_engine_unit_tb.sv =====
`timescale 1ns / 1ps

module stack_to_multi_queue_engine_unit_tb;
	import smq_pkg::*;

	localparam int STK_DEPTH = DEF_STACK_DEPTH;
	localparam int Q_DEPTH   = DEF_QUEUE_DEPTH;
	localparam int NUM_Q     = DEF_NUM_QUEUES;
	localparam logic [7:0] DMASK = 8'((1 << DEF_DATA_WIDTH) - 1);
	localparam int NUM_DIR   = 21;
	localparam int NUM_RAND  = 700;

	typedef struct packed {
		cmd_item_t it;
		logic      typed;
		rsp_item_t rsp;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd_item = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp_item;

	stack_to_multi_queue_engine_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	always #4 clk = ~clk;

	// shadow copy of the engine state
	logic [7:0] stk_mem [STK_DEPTH];
	int         stk_cnt = 0;
	logic [7:0] q_mem [NUM_Q][Q_DEPTH];
	int         q_head [NUM_Q];
	int         q_tail [NUM_Q];
	int         q_cnt [NUM_Q];

	rsp_item_t  rsp_expected [$];
	rsp_item_t  head_rsp;
	int         n_bad = 0;
	int         n_acc = 0;
	int         n_rand = 0;
	int         send_idle_pct = 10;
	int         recv_stall_pct = 63;
	logic       hold_go = 1'b0;
	logic       hold_done = 1'b0;
	int         hold_left = 0;
	logic [4:0] hot_q = '0;

	// typed rows carry their own expected result, the rest come from the shadow model
	dir_row_t dir_tab [NUM_DIR] = '{
		{CMD_DEQUEUE, 8'h00, 5'd0,  1'b1, STAT_QUEUE_EMPTY, 8'h00},
		{CMD_ENQUEUE, 8'h00, 5'd0,  1'b1, STAT_STACK_EMPTY, 8'h00},
		{CMD_ENQUEUE, 8'hff, 5'd31, 1'b1, STAT_STACK_EMPTY, 8'h00},
		{CMD_DEQUEUE, 8'hff, 5'd31, 1'b1, STAT_QUEUE_EMPTY, 8'h00},
		{CMD_NOP,     8'hff, 5'd31, 1'b1, STAT_OK,          8'h00},
		{CMD_PUSH,    8'hff, 5'd0,  1'b1, STAT_OK,          8'h00},
		{CMD_PUSH,    8'h00, 5'd31, 1'b1, STAT_OK,          8'h00},
		{CMD_ENQUEUE, 8'h00, 5'd26, 1'b1, STAT_QUEUE_FULL,  8'h00},
		{CMD_ENQUEUE, 8'hff, 5'd31, 1'b1, STAT_QUEUE_FULL,  8'h00},
		{CMD_ENQUEUE, 8'h00, 5'd25, 1'b0, STAT_OK,          8'h00},
		{CMD_ENQUEUE, 8'h00, 5'd0,  1'b0, STAT_OK,          8'h00},
		{CMD_DEQUEUE, 8'h00, 5'd25, 1'b0, STAT_OK,          8'h00},
		{CMD_DEQUEUE, 8'h00, 5'd0,  1'b0, STAT_OK,          8'h00},
		{CMD_DEQUEUE, 8'h00, 5'd0,  1'b1, STAT_QUEUE_EMPTY, 8'h00},
		{CMD_PUSH,    8'ha5, 5'd21, 1'b0, STAT_OK,          8'h00},
		{CMD_PUSH,    8'h5a, 5'd10, 1'b0, STAT_OK,          8'h00},
		{CMD_ENQUEUE, 8'hff, 5'd16, 1'b0, STAT_OK,          8'h00},
		{CMD_ENQUEUE, 8'h00, 5'd15, 1'b0, STAT_OK,          8'h00},
		{CMD_DEQUEUE, 8'hff, 5'd15, 1'b0, STAT_OK,          8'h00},
		{CMD_DEQUEUE, 8'h00, 5'd16, 1'b0, STAT_OK,          8'h00},
		{CMD_NOP,     8'h00, 5'd0,  1'b1, STAT_OK,          8'h00}
	};

	function automatic int wrap_next(input int pos);
		return (pos + 1 >= Q_DEPTH) ? 0 : pos + 1;
	endfunction

	function automatic rsp_item_t engine_step(input cmd_item_t it);
		rsp_item_t r;
		logic      qok;
		int        qid;
		qid = int'(it.queue_id);
		qok = qid < NUM_Q;
		r.status = STAT_OK;
		r.out_value = '0;
		case (it.cmd)
			CMD_PUSH: begin
				if (stk_cnt >= STK_DEPTH) begin
					r.status = STAT_STACK_FULL;
				end else begin
					stk_mem[stk_cnt] = it.value & DMASK;
					stk_cnt++;
				end
			end
			CMD_ENQUEUE: begin
				if (stk_cnt == 0) begin
					r.status = STAT_STACK_EMPTY;
				end else if (!qok || q_cnt[qid] >= Q_DEPTH) begin
					r.status = STAT_QUEUE_FULL;
				end else begin
					stk_cnt--;
					q_mem[qid][q_tail[qid]] = stk_mem[stk_cnt];
					q_tail[qid] = wrap_next(q_tail[qid]);
					q_cnt[qid]++;
				end
			end
			CMD_DEQUEUE: begin
				if (!qok || q_cnt[qid] == 0) begin
					r.status = STAT_QUEUE_EMPTY;
				end else begin
					r.out_value = q_mem[qid][q_head[qid]];
					q_head[qid] = wrap_next(q_head[qid]);
					q_cnt[qid]--;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// called right after a rising edge; returns at the edge the item is taken
	task automatic issue_cmd(input cmd_item_t it, input logic typed = 1'b0,
			input rsp_item_t typed_rsp = '0);
		rsp_item_t pred;
		if (n_acc < 240) begin
			send_idle_pct = 10;
			recv_stall_pct = 63;
		end else if (n_acc < 480) begin
			send_idle_pct = 63;
			recv_stall_pct = 10;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
			hold_go = 1'b1;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= it;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		pred = engine_step(it);
		rsp_expected.push_back(typed ? typed_rsp : pred);
		n_acc++;
	endtask

	function automatic logic [4:0] pick_qid();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return hot_q;
		else if (r < 93)
			return 5'($urandom_range(0, NUM_Q - 1));
		return 5'($urandom_range(NUM_Q, 31));
	endfunction

	function automatic cmd_item_t mk_item(input logic [1:0] c, input logic [4:0] qid);
		cmd_item_t it;
		it.cmd = c;
		it.value = 8'($urandom_range(0, 255));
		it.queue_id = qid;
		return it;
	endfunction

	// short bursts of mostly one kind keep stack and queues moving in and out
	task automatic mixed_bursts(input int upto);
		int kind;
		int len;
		logic [1:0] c;
		while (n_rand < upto) begin
			kind = $urandom_range(0, 9);
			len = $urandom_range(1, 12);
			hot_q = 5'($urandom_range(0, NUM_Q - 1));
			repeat (len) begin
				if (kind <= 2)
					c = CMD_PUSH;
				else if (kind <= 5)
					c = CMD_ENQUEUE;
				else if (kind <= 8)
					c = CMD_DEQUEUE;
				else
					c = 2'($urandom_range(0, 3));
				if ($urandom_range(0, 99) < 15)
					c = 2'($urandom_range(0, 3));
				issue_cmd(mk_item(c, pick_qid()));
				n_rand++;
			end
		end
	endtask

	// stack to full, one queue to full with wraparound, then drain it past empty
	task automatic fill_and_drain(input logic [4:0] qn);
		while (stk_cnt < STK_DEPTH) begin
			issue_cmd(mk_item(CMD_PUSH, pick_qid()));
			n_rand++;
		end
		repeat (2) begin
			issue_cmd(mk_item(CMD_PUSH, pick_qid()));
			n_rand++;
		end
		while (q_cnt[qn] < Q_DEPTH) begin
			if (stk_cnt == 0) begin
				issue_cmd(mk_item(CMD_PUSH, qn));
				n_rand++;
			end
			issue_cmd(mk_item(CMD_ENQUEUE, qn));
			n_rand++;
		end
		if (stk_cnt == 0) begin
			issue_cmd(mk_item(CMD_PUSH, qn));
			n_rand++;
		end
		issue_cmd(mk_item(CMD_ENQUEUE, qn));
		n_rand++;
		while (q_cnt[qn] > 0) begin
			issue_cmd(mk_item(CMD_DEQUEUE, qn));
			n_rand++;
		end
		issue_cmd(mk_item(CMD_DEQUEUE, qn));
		n_rand++;
	endtask

	// receiver: random stall, plus one long hold-off to back up the engine
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left = 300;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expected.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected item: status %0d out_value %02h",
						rsp_item.status, rsp_item.out_value);
			end else begin
				head_rsp = rsp_expected.pop_front();
				if (rsp_item.status !== head_rsp.status ||
						rsp_item.out_value !== head_rsp.out_value) begin
					n_bad++;
					if (n_bad <= 10)
						$display("bad item: status %0d exp %0d, out_value %02h exp %02h",
							rsp_item.status, head_rsp.status,
							rsp_item.out_value, head_rsp.out_value);
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_Q; i++) begin
			q_head[i] = 0;
			q_tail[i] = 0;
			q_cnt[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NUM_DIR; i++)
			issue_cmd(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].rsp);
		mixed_bursts(100);
		fill_and_drain(5'($urandom_range(0, NUM_Q - 1)));
		mixed_bursts(NUM_RAND);
		cmd_valid <= 1'b0;
		while (rsp_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_bad == 0)
			$display("stack_to_multi_queue_engine_unit: match");
		else
			$display("stack_to_multi_queue_engine_unit: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("stack_to_multi_queue_engine_unit: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
src/smq_pkg.sv
src/smq_ctrl.sv
src/smq_dpath.sv
src/stack_to_multi_queue_engine_unit.sv
tb/sv/stack_to_multi_queue_engine_unit_tb.sv
